### src/mmc3_outer_bank_translator_defines.svh
`ifndef MMC3_OUTER_BANK_TRANSLATOR_DEFINES_SVH
`define MMC3_OUTER_BANK_TRANSLATOR_DEFINES_SVH

// Checks that a condition in the same cycle implies another.
`define MOBT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies another in the next cycle.
`define MOBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mobt_pkg.sv
package mobt_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_PRG   = 2'd1,
        OP_CHR   = 2'd2,
        OP_NONE  = 2'd3
    } mobt_op_t;

    localparam int PRG_BANK_BITS_DEF = 13;
    localparam int PRG_SUM_W         = 13;

    localparam logic [2:0] VAR_SCRAMBLE    = 3'd1;
    localparam logic [2:0] VAR_HIGH_OFFSET = 3'd2;
    localparam logic [2:0] VAR_SECOND_CHIP = 3'd3;
    localparam logic [2:0] VAR_CHR_PROTECT = 3'd4;

    localparam logic CFG_VARIANT     = 1'b0;
    localparam logic CFG_CHIP_OFFSET = 1'b1;

    localparam logic [1:0] REG_LOCK_EXEMPT = 2'd2;

    localparam logic [7:0] SCRAMBLE_KEEP  = 8'b1110_0101;
    localparam logic [7:0] HIGH_OFF_KEEP  = 8'b1110_0011;
    localparam logic [7:0] MASK_BASE      = 8'b0011_1111;
    localparam logic [7:0] LAST_BANK_MIN  = 8'hFE;

endpackage

### src/mmc3_outer_bank_translator.sv
// Output: the result of an accepted word is registered in the single output register.
// Throughput: one word per cycle while m_ready is high; the next word is taken while
// the result is taken, set by the single output register.
// Reset: aresetn clears the four outer registers, both configuration registers
// and the output valid flag.
`include "mmc3_outer_bank_translator_defines.svh"

module mmc3_outer_bank_translator
    import mobt_pkg::*;
#(
    parameter int PRG_BANK_BITS = PRG_BANK_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_opcode,
    input  logic [15:0]              s_bus_address,
    input  logic [7:0]               s_data_value,
    input  logic                     s_prg_mode_swap,
    input  logic                     s_chr_mode_invert,
    input  logic [7:0]               s_chr_reg_first,
    input  logic [7:0]               s_chr_reg_second,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [PRG_BANK_BITS-1:0] m_prg_bank,
    output logic [9:0]               m_chr_bank,
    output logic                     m_chr_write_protect,
    output logic                     m_write_taken,

    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [11:0]              cfg_wdata
);

    logic [7:0]               outer_regs_reg [4];
    logic [2:0]               board_variant_reg;
    logic [11:0]              second_chip_offset_reg;

    logic                     out_valid_reg;
    logic [PRG_BANK_BITS-1:0] prg_bank_reg;
    logic [9:0]               chr_bank_reg;
    logic                     chr_wp_reg;
    logic                     write_taken_reg;

    logic                     accept;
    logic                     locked;
    logic                     take_write;

    logic [7:0]               c0;
    logic [7:0]               c1;
    logic [7:0]               c3;
    logic [7:0]               prg_mask;
    logic [7:0]               prg_base;
    logic [7:0]               prg_value;
    logic [11:0]              prg_off;
    logic [11:0]              prg_merged;
    logic [2:0]               extra_bits;
    logic [PRG_SUM_W-1:0]     prg_sum;
    logic [PRG_BANK_BITS+PRG_SUM_W-1:0] prg_ext;
    logic [PRG_BANK_BITS-1:0] prg_next;

    logic [7:0]               r0;
    logic [7:0]               r2;
    logic [7:0]               r3;
    logic [7:0]               chr_mask;
    logic [2:0]               chr_slot;
    logic [2:0]               chr_key;
    logic [7:0]               chr_value;
    logic [7:0]               chr_hi;
    logic [9:0]               chr_next;

    logic [PRG_BANK_BITS-1:0] prg_bank_next;
    logic [9:0]               chr_bank_next;
    logic                     chr_wp_next;
    logic                     write_taken_next;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign locked     = outer_regs_reg[3][7] && !outer_regs_reg[3][4];
    assign take_write = !locked || (s_bus_address[1:0] == REG_LOCK_EXEMPT);

    always_comb begin
        c0 = outer_regs_reg[0];
        c1 = outer_regs_reg[1];
        c3 = outer_regs_reg[3];
        if (board_variant_reg == VAR_SCRAMBLE) begin
            c1 = (c1 & SCRAMBLE_KEEP) | {3'b000, c1[3], c1[1], 1'b0, !c1[4], 1'b0};
        end
        if (board_variant_reg == VAR_HIGH_OFFSET) begin
            c1 = (c1 & HIGH_OFF_KEEP) | {3'b000, c0[4], 1'b0, c0[5], 2'b00};
            c0 = {c0[7:6], 2'b00, c0[3:0]};
        end
        prg_mask = (MASK_BASE | {c1[5], c1[6], 6'b000000})
                 ^ {2'b00, c1[7], c0[6], 4'b0000};
        prg_base = {c0[5:4], c1[3:2], c1[4], c0[2:0]};

        if ((board_variant_reg == VAR_SECOND_CHIP) && outer_regs_reg[0][3]) begin
            prg_off = second_chip_offset_reg;
        end else begin
            prg_off = '0;
        end

        prg_value = s_data_value;
        if (c3[6] && (s_data_value >= LAST_BANK_MIN) && !s_prg_mode_swap
                && (s_bus_address[15:14] == 2'b11)) begin
            prg_value = '0;
        end

        if (c1[1]) begin
            extra_bits = {c3[3:2], s_bus_address[14]};
        end else begin
            extra_bits = c3[3:1];
        end

        if (!c3[4]) begin
            prg_merged = ({prg_base, 4'b0000} & ~{4'b0000, prg_mask})
                       | {4'b0000, prg_value & prg_mask};
        end else begin
            prg_merged = ({prg_base, 4'b0000} & ~{4'b0000, prg_mask[7:4], 4'b0000})
                       | {4'b0000, prg_value[7:4] & prg_mask[7:4],
                          extra_bits, s_bus_address[13]};
        end
        prg_sum  = {1'b0, prg_merged} + {1'b0, prg_off};
        prg_ext  = {{PRG_BANK_BITS{1'b0}}, prg_sum};
        prg_next = prg_ext[PRG_BANK_BITS-1:0];
    end

    always_comb begin
        r0        = outer_regs_reg[0];
        r2        = outer_regs_reg[2];
        r3        = outer_regs_reg[3];
        chr_mask  = {!r0[7], 7'h7F};
        chr_slot  = s_bus_address[12:10];
        chr_key   = {chr_slot[2] ^ s_chr_mode_invert, chr_slot[1:0]};
        chr_hi    = {r0[3] && r0[7], 7'h00};
        chr_value = s_data_value;
        if (r3[4]) begin
            if (r3[6] && !chr_key[2] && chr_key[0]) begin
                chr_value[7] = 1'b0;
            end
            chr_next = {r0[5:4], (chr_value[7] & chr_mask[7]) | chr_hi[7], r2[3:0], chr_slot};
        end else begin
            if (r3[6]) begin
                unique if (chr_key == 3'b000) begin
                    chr_value = s_chr_reg_first;
                end else if (chr_key == 3'b010) begin
                    chr_value = s_chr_reg_second;
                end else if (!chr_key[2] && chr_key[0]) begin
                    chr_value = '0;
                end else begin
                    chr_value = s_data_value;
                end
            end
            chr_next = {r0[5:4], (chr_value & chr_mask) | chr_hi};
        end
    end

    always_comb begin
        prg_bank_next    = '0;
        chr_bank_next    = '0;
        chr_wp_next      = 1'b0;
        write_taken_next = 1'b0;
        unique case (mobt_op_t'(s_opcode))
            OP_WRITE: begin
                write_taken_next = take_write;
            end
            OP_PRG: begin
                prg_bank_next = prg_next;
            end
            OP_CHR: begin
                chr_bank_next = chr_next;
                chr_wp_next   = (board_variant_reg == VAR_CHR_PROTECT) && outer_regs_reg[0][4];
            end
            OP_NONE: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                outer_regs_reg[i] <= '0;
            end
            board_variant_reg      <= '0;
            second_chip_offset_reg <= '0;
            out_valid_reg          <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_VARIANT:     board_variant_reg      <= cfg_wdata[2:0];
                    CFG_CHIP_OFFSET: second_chip_offset_reg <= cfg_wdata;
                endcase
            end
            if (accept && (mobt_op_t'(s_opcode) == OP_WRITE) && take_write) begin
                outer_regs_reg[s_bus_address[1:0]] <= s_data_value;
            end
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prg_bank_reg    <= prg_bank_next;
            chr_bank_reg    <= chr_bank_next;
            chr_wp_reg      <= chr_wp_next;
            write_taken_reg <= write_taken_next;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_prg_bank          = prg_bank_reg;
    assign m_chr_bank          = chr_bank_reg;
    assign m_chr_write_protect = chr_wp_reg;
    assign m_write_taken       = write_taken_reg;

    `MOBT_ASSERT_NEXT(a_accept_gives_word, accept, out_valid_reg,
        "accepted word produced no result")
    `MOBT_ASSERT_NEXT(a_locked_write_refused,
        accept && (s_opcode == OP_WRITE) && locked && (s_bus_address[1:0] != REG_LOCK_EXEMPT),
        !write_taken_reg, "locked write reported as taken")
    `MOBT_ASSERT_NEXT(a_exempt_write_stored,
        accept && (s_opcode == OP_WRITE) && (s_bus_address[1:0] == REG_LOCK_EXEMPT),
        outer_regs_reg[2] == $past(s_data_value), "register 2 write not stored")
    `MOBT_ASSERT_NEXT(a_prg_zero_other_ops, accept && (s_opcode != OP_PRG),
        prg_bank_reg == '0, "PRG bank nonzero on non-PRG word")
    `MOBT_ASSERT_SAME(a_wp_only_variant4, out_valid_reg && chr_wp_reg,
        board_variant_reg == VAR_CHR_PROTECT, "write protect outside CHR protect variant")

endmodule

### dv/tb.sv
module tb
    import mobt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRG_W = PRG_BANK_BITS_DEF;
    localparam int RANDOM_WORDS = 60;
    localparam int LOCKED_WORDS = 40;
    localparam int STALL_LIMIT = 2000;
    localparam logic [2:0] VAR_PLAIN = 3'd0;
    localparam logic [2:0] VAR_ALIAS = 3'd7;
    localparam logic [1:0] REG_MODE = 2'd3;

    typedef struct packed {
        logic [PRG_W-1:0] prg;
        logic [9:0]       chr;
        logic             wp;
        logic             taken;
    } bank_result_t;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_opcode = OP_NONE;
    logic [15:0]       s_bus_address = '0;
    logic [7:0]        s_data_value = '0;
    logic              s_prg_mode_swap = 1'b0;
    logic              s_chr_mode_invert = 1'b0;
    logic [7:0]        s_chr_reg_first = '0;
    logic [7:0]        s_chr_reg_second = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [PRG_W-1:0]  m_prg_bank;
    logic [9:0]        m_chr_bank;
    logic              m_chr_write_protect;
    logic              m_write_taken;
    logic              cfg_we = 1'b0;
    logic              cfg_index = CFG_VARIANT;
    logic [11:0]       cfg_wdata = '0;

    logic [7:0]        outer_copy [4] = '{default: 8'h00};
    logic [2:0]        variant_cfg = VAR_PLAIN;
    logic [11:0]       chip_offset_cfg = '0;
    bank_result_t      expected_banks [$];
    int unsigned       src_idle_pct = 0;
    int unsigned       sink_idle_pct = 0;
    int                words_sent = 0;
    int                results_checked = 0;
    int                error_count = 0;
    int                stall_cycles = 0;

    mmc3_outer_bank_translator uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_opcode            (s_opcode),
        .s_bus_address       (s_bus_address),
        .s_data_value        (s_data_value),
        .s_prg_mode_swap     (s_prg_mode_swap),
        .s_chr_mode_invert   (s_chr_mode_invert),
        .s_chr_reg_first     (s_chr_reg_first),
        .s_chr_reg_second    (s_chr_reg_second),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_prg_bank          (m_prg_bank),
        .m_chr_bank          (m_chr_bank),
        .m_chr_write_protect (m_chr_write_protect),
        .m_write_taken       (m_write_taken),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [PRG_W-1:0] predict_prg(logic [15:0] addr, logic [7:0] bank,
                                                      logic swap);
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic [7:0]  c3;
        logic [7:0]  mask;
        logic [7:0]  base;
        logic [7:0]  low_bits;
        logic [31:0] base_w;
        logic [31:0] offset;
        logic [31:0] sum;
        c0 = outer_copy[0];
        c1 = outer_copy[1];
        c3 = outer_copy[3];
        if (variant_cfg == VAR_SCRAMBLE) begin
            c1 = (c1 & 8'hE5) | ((c1 & 8'h08) << 1) | ((c1 & 8'h02) << 2)
               | (((c1 ^ 8'h10) & 8'h10) >> 3);
        end
        if (variant_cfg == VAR_HIGH_OFFSET) begin
            c1 = (c1 & 8'hE3) | ((c0 & 8'h20) >> 3) | (c0 & 8'h10);
            c0 = c0 & 8'hCF;
        end
        mask = ((8'h3F | (c1 & 8'h40) | ((c1 & 8'h20) << 2)) ^ ((c0 & 8'h40) >> 2))
             ^ ((c1 & 8'h80) >> 2);
        base = (c0 & 8'h07) | ((c1 & 8'h10) >> 1) | ((c1 & 8'h0C) << 2) | ((c0 & 8'h30) << 2);
        base_w = {24'b0, base} << 4;
        offset = '0;
        if (variant_cfg == VAR_SECOND_CHIP && outer_copy[0][3])
            offset = {20'b0, chip_offset_cfg};
        // The last two banks fold to bank zero in the upper CPU window.
        if (c3[6] && bank >= LAST_BANK_MIN && !swap && addr[15:14] == 2'b11)
            bank = 8'h00;
        if (!c3[4]) begin
            sum = ((base_w & ~{24'b0, mask}) | {24'b0, bank & mask}) + offset;
        end else begin
            mask = mask & 8'hF0;
            if (c1[1])
                low_bits = (c3 & 8'h0C) | {6'b0, addr[14], 1'b0};
            else
                low_bits = c3 & 8'h0E;
            sum = ((base_w & ~{24'b0, mask}) | {24'b0, bank & mask} | {24'b0, low_bits}
                | {31'b0, addr[13]}) + offset;
        end
        return sum[PRG_W-1:0];
    endfunction

    function automatic logic [9:0] predict_chr(logic [15:0] addr, logic [7:0] bank, logic inv,
                                               logic [7:0] first, logic [7:0] second);
        logic [7:0] r0;
        logic [7:0] r2;
        logic [7:0] r3;
        logic [7:0] mask;
        logic [7:0] hi;
        logic [2:0] key;
        logic [9:0] res;
        r0 = outer_copy[0];
        r2 = outer_copy[2];
        r3 = outer_copy[3];
        mask = 8'hFF ^ (r0 & 8'h80);
        hi = ((r0 & 8'h08) << 4) & ~mask;
        key = {inv ^ addr[12], addr[11:10]};
        if (r3[4]) begin
            if (r3[6] && (key == 3'd1 || key == 3'd3))
                bank[7] = 1'b0;
            res = {2'b0, bank & 8'h80 & mask} | {2'b0, hi} | {3'b0, r2[3:0], 3'b0}
                | {7'b0, addr[12:10]} | {r0[5:4], 8'b0};
        end else begin
            if (r3[6]) begin
                case (key)
                    3'd0: bank = first;
                    3'd2: bank = second;
                    3'd1, 3'd3: bank = 8'h00;
                    default: ;
                endcase
            end
            res = {2'b0, bank & mask} | {2'b0, hi} | {r0[5:4], 8'b0};
        end
        return res;
    endfunction

    function automatic bank_result_t predict_word(mobt_op_t op, logic [15:0] addr,
                                                  logic [7:0] data, logic swap, logic inv,
                                                  logic [7:0] first, logic [7:0] second);
        bank_result_t r;
        r = '0;
        case (op)
            OP_WRITE: begin
                if ((outer_copy[3] & 8'h90) != 8'h80 || addr[1:0] == REG_LOCK_EXEMPT) begin
                    outer_copy[addr[1:0]] = data;
                    r.taken = 1'b1;
                end
            end
            OP_PRG: r.prg = predict_prg(addr, data, swap);
            OP_CHR: begin
                r.chr = predict_chr(addr, data, inv, first, second);
                if (variant_cfg == VAR_CHR_PROTECT)
                    r.wp = outer_copy[0][4];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic compare_field(input string label, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
        end
    endtask

    always @(posedge aclk) begin
        bank_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_banks.size() == 0) begin
                error_count++;
                $display("%0t ns: unexpected word, expected none, actual %0h %0h %0b %0b",
                         $time, m_prg_bank, m_chr_bank, m_chr_write_protect, m_write_taken);
            end else begin
                want = expected_banks.pop_front();
                compare_field("prg_bank", 16'(want.prg), 16'(m_prg_bank));
                compare_field("chr_bank", 16'(want.chr), 16'(m_chr_bank));
                compare_field("chr_write_protect", 16'(want.wp), 16'(m_chr_write_protect));
                compare_field("write_taken", 16'(want.taken), 16'(m_write_taken));
                results_checked++;
            end
        end
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_word(input mobt_op_t op, input logic [15:0] addr, input logic [7:0] data,
                             input logic swap, input logic inv, input logic [7:0] first,
                             input logic [7:0] second);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_bus_address <= addr;
        s_data_value <= data;
        s_prg_mode_swap <= swap;
        s_chr_mode_invert <= inv;
        s_chr_reg_first <= first;
        s_chr_reg_second <= second;
        do @(posedge aclk); while (!s_ready);
        expected_banks.push_back(predict_word(op, addr, data, swap, inv, first, second));
        words_sent++;
    endtask

    task automatic send_random_word(input bit allow_lock);
        int unsigned pick;
        mobt_op_t    op;
        logic [15:0] addr;
        logic [7:0]  data;
        pick = $urandom_range(19);
        addr = 16'($urandom);
        data = 8'($urandom);
        if (pick < 5) begin
            op = OP_WRITE;
            // Keep the mode register out of the lockout until the lockout phase.
            if (!allow_lock && addr[1:0] == REG_MODE && data[7] && !data[4])
                data[7] = 1'b0;
        end else if (pick < 12) begin
            op = OP_PRG;
            if ($urandom_range(3) == 0)
                data[7:1] = 7'h7F;
        end else if (pick < 19) begin
            op = OP_CHR;
        end else begin
            op = OP_NONE;
        end
        send_word(op, addr, data, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (expected_banks.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_setting(input logic index, input logic [11:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (index == CFG_VARIANT)
            variant_cfg = value[2:0];
        else
            chip_offset_cfg = value;
        @(posedge aclk);
    endtask

    task automatic test_after_reset();
        send_word(OP_PRG, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 8'hFF, 8'hFF);
        send_word(OP_CHR, 16'h0000, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(OP_NONE, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 8'hFF, 8'hFF);
    endtask

    task automatic test_register_writes();
        send_word(OP_WRITE, 16'hFFFC, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(OP_WRITE, 16'h0001, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(OP_WRITE, 16'h8002, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(OP_WRITE, 16'h7FF3, 8'h50, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(OP_PRG, 16'hE000, 8'hFE, 1'b0, 1'b0, 8'h00, 8'h00);
    endtask

    task automatic test_prg_paths();
        send_word(OP_PRG, 16'h6000, 8'hFF, 1'b1, 1'b0, 8'h00, 8'h00);
        send_word(OP_WRITE, 16'h0005, 8'h02, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(OP_PRG, 16'hC000, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(OP_WRITE, 16'h0003, 8'h40, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(OP_PRG, 16'hE000, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(OP_PRG, 16'hC000, 8'hFE, 1'b1, 1'b0, 8'h00, 8'h00);
        send_word(OP_PRG, 16'hA000, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00);
    endtask

    task automatic test_chr_paths();
        send_word(OP_CHR, 16'h0000, 8'h11, 1'b0, 1'b0, 8'hA5, 8'h5A);
        send_word(OP_CHR, 16'h0800, 8'h11, 1'b0, 1'b0, 8'hA5, 8'h5A);
        send_word(OP_CHR, 16'h0400, 8'hFF, 1'b0, 1'b0, 8'hA5, 8'h5A);
        send_word(OP_CHR, 16'h1C00, 8'hFF, 1'b0, 1'b1, 8'hA5, 8'h5A);
        send_word(OP_CHR, 16'h1000, 8'hFF, 1'b0, 1'b1, 8'hC3, 8'h3C);
        send_word(OP_CHR, 16'h1400, 8'h3C, 1'b0, 1'b0, 8'hFF, 8'hFF);
        send_word(OP_WRITE, 16'h0003, 8'h50, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(OP_CHR, 16'h0400, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(OP_CHR, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 8'hFF, 8'hFF);
    endtask

    task automatic test_random_traffic(input logic [2:0] variant, input logic [11:0] offset);
        settle();
        write_setting(CFG_VARIANT, {9'b0, variant});
        write_setting(CFG_CHIP_OFFSET, offset);
        repeat (RANDOM_WORDS) send_random_word(1'b0);
    endtask

    task automatic test_lockout();
        settle();
        write_setting(CFG_VARIANT, {9'b0, VAR_SECOND_CHIP});
        write_setting(CFG_CHIP_OFFSET, 12'($urandom_range(4095)));
        send_word(OP_WRITE, 16'h0003, 8'h80, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(OP_WRITE, 16'h0000, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(OP_WRITE, 16'h0001, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(OP_WRITE, 16'h0003, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(OP_WRITE, 16'hFFFE, 8'hA5, 1'b0, 1'b0, 8'h00, 8'h00);
        repeat (LOCKED_WORDS) send_random_word(1'b1);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        src_idle_pct = 20;
        sink_idle_pct = 81;
        test_after_reset();
        test_register_writes();
        test_prg_paths();
        test_chr_paths();
        test_random_traffic(VAR_PLAIN, 12'h000);
        test_random_traffic(VAR_SCRAMBLE, 12'hFFF);

        src_idle_pct = 81;
        sink_idle_pct = 20;
        test_random_traffic(VAR_HIGH_OFFSET, 12'($urandom_range(4095)));
        test_random_traffic(VAR_SECOND_CHIP, 12'hFFF);

        src_idle_pct = 0;
        sink_idle_pct = 0;
        test_random_traffic(VAR_CHR_PROTECT, 12'($urandom_range(4095)));
        test_random_traffic(VAR_ALIAS, 12'h000);
        test_lockout();

        settle();
        $display("Sent %0d words across board variants 0 to 4 and 7, then the register lockout.",
                 words_sent);
        $display("Compared %0d result words; %0d field mismatches.", results_checked, error_count);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
